/* sv/qlao_pkg.sv */
// shared types, widths and constants of the quaternion lever-arm offset block
// no dependencies; used by every module under sv/
`default_nettype none

package qlao_pkg;

	localparam int QW    = 18;          // quaternion component, Q2.16
	localparam int PW    = 32;          // position and centre, Q16.16
	localparam int OW    = 21;          // lever arm component
	localparam int CW    = 2;           // confidence
	localparam int AW    = 2;           // register index
	localparam int PRODW = 2 * QW;      // quaternion product, Q.32
	localparam int ENTW  = PRODW + 2;   // matrix entry, Q.32 with headroom
	localparam int MULW  = ENTW + OW;   // entry times arm, Q.48
	localparam int SUMW  = MULW + 2;    // sum of three Q.48 terms
	localparam int FRACW = 32;          // fraction bits dropped in rounding
	localparam int ROTW  = SUMW - FRACW;
	localparam int DIFW  = PW + 1;

	localparam logic signed [ENTW-1:0] NORM_LO = ENTW'(64'sd4294108346);
	localparam logic signed [ENTW-1:0] NORM_HI = ENTW'(64'sd4295826332);
	localparam logic signed [ENTW-1:0] ONE_Q32 = ENTW'(64'sd4294967296);
	localparam logic signed [SUMW-1:0] HALF_Q32 = SUMW'(64'sd2147483648);

	localparam logic [AW-1:0] CFG_OFFSET_X = 2'd0;
	localparam logic [AW-1:0] CFG_OFFSET_Y = 2'd1;
	localparam logic [AW-1:0] CFG_OFFSET_Z = 2'd2;

	typedef struct packed {
		logic signed [QW-1:0] w;
		logic signed [QW-1:0] x;
		logic signed [QW-1:0] y;
		logic signed [QW-1:0] z;
	} quat_t;

	typedef struct packed {
		logic signed [PW-1:0] x;
		logic signed [PW-1:0] y;
		logic signed [PW-1:0] z;
	} vec_t;

	typedef struct packed {
		logic signed [OW-1:0] x;
		logic signed [OW-1:0] y;
		logic signed [OW-1:0] z;
	} arm_t;

	typedef struct packed {
		logic signed [ROTW-1:0] x;
		logic signed [ROTW-1:0] y;
		logic signed [ROTW-1:0] z;
	} rot_t;

	// data that rides along the pipe untouched
	typedef struct packed {
		vec_t          pos;
		logic [CW-1:0] conf;
	} side_t;

	typedef struct packed {
		logic signed [PRODW-1:0] ww;
		logic signed [PRODW-1:0] xx;
		logic signed [PRODW-1:0] yy;
		logic signed [PRODW-1:0] zz;
		logic signed [PRODW-1:0] wx;
		logic signed [PRODW-1:0] wy;
		logic signed [PRODW-1:0] wz;
		logic signed [PRODW-1:0] xy;
		logic signed [PRODW-1:0] xz;
		logic signed [PRODW-1:0] yz;
	} prod_t;

	typedef struct packed {
		logic signed [ENTW-1:0] r00;
		logic signed [ENTW-1:0] r01;
		logic signed [ENTW-1:0] r02;
		logic signed [ENTW-1:0] r10;
		logic signed [ENTW-1:0] r11;
		logic signed [ENTW-1:0] r12;
		logic signed [ENTW-1:0] r20;
		logic signed [ENTW-1:0] r21;
		logic signed [ENTW-1:0] r22;
	} mat_t;

	function automatic logic signed [PW-1:0] sat_pw(input logic signed [DIFW-1:0] v);
		logic signed [PW-1:0] r;
		if (v[DIFW-1] != v[DIFW-2]) begin
			r = v[DIFW-1] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
		end else begin
			r = v[PW-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* sv/quaternion_lever_arm_offset_top.sv */
// top level: lever arm registers, pipeline hookup, final subtract and saturation
// depends on qlao_pkg, qlao_prod, qlao_matrix, qlao_rotate
`default_nettype none

// Takes one pose per clock cycle; busy is always low, and the result appears
// on done with no way to hold it off. Each pose passes through the five
// register stages: quaternion products, norm test and matrix, matrix-arm
// multiplies, rounded row sums, subtract and saturate. A pose whose squared
// quaternion norm falls outside the 1 +/- 2e-4 window gives no done pulse at
// all. Write the offset registers only while no pose is in flight.
module quaternion_lever_arm_offset_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [qlao_pkg::AW-1:0]       cfg_addr,
	input  wire logic [qlao_pkg::OW-1:0]       cfg_wdata,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [qlao_pkg::QW-1:0] quat_w,
	input  wire logic signed [qlao_pkg::QW-1:0] quat_x,
	input  wire logic signed [qlao_pkg::QW-1:0] quat_y,
	input  wire logic signed [qlao_pkg::QW-1:0] quat_z,
	input  wire logic signed [qlao_pkg::PW-1:0] pos_x,
	input  wire logic signed [qlao_pkg::PW-1:0] pos_y,
	input  wire logic signed [qlao_pkg::PW-1:0] pos_z,
	input  wire logic [qlao_pkg::CW-1:0]       confidence,
	output logic                               done,
	output logic signed [qlao_pkg::PW-1:0]     center_x,
	output logic signed [qlao_pkg::PW-1:0]     center_y,
	output logic signed [qlao_pkg::PW-1:0]     center_z,
	output logic [qlao_pkg::CW-1:0]            confidence_out
);

	localparam int DIFW = qlao_pkg::DIFW;

	qlao_pkg::arm_t  arm_q;
	qlao_pkg::quat_t quat;
	qlao_pkg::side_t side_in;
	logic            accept;

	logic            valid_s1, valid_s2, valid_s4, valid_s5;
	qlao_pkg::prod_t prod_s1;
	qlao_pkg::mat_t  mat_s2;
	qlao_pkg::rot_t  rot_s4;
	qlao_pkg::side_t side_s1, side_s2, side_s4;
	qlao_pkg::vec_t  center_s5;
	logic [qlao_pkg::CW-1:0] conf_s5;

	logic signed [DIFW-1:0] dif_x, dif_y, dif_z;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_comb begin
		quat.w = quat_w;
		quat.x = quat_x;
		quat.y = quat_y;
		quat.z = quat_z;
		side_in.pos.x = pos_x;
		side_in.pos.y = pos_y;
		side_in.pos.z = pos_z;
		side_in.conf  = confidence;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				qlao_pkg::CFG_OFFSET_X: arm_q.x <= cfg_wdata;
				qlao_pkg::CFG_OFFSET_Y: arm_q.y <= cfg_wdata;
				qlao_pkg::CFG_OFFSET_Z: arm_q.z <= cfg_wdata;
				default: ;
			endcase
		end
	end

	qlao_prod u_prod (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.quat     (quat),
		.side     (side_in),
		.valid_s1 (valid_s1),
		.prod_s1  (prod_s1),
		.side_s1  (side_s1)
	);

	qlao_matrix u_matrix (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.prod_s1  (prod_s1),
		.side_s1  (side_s1),
		.valid_s2 (valid_s2),
		.mat_s2   (mat_s2),
		.side_s2  (side_s2)
	);

	qlao_rotate u_rotate (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.mat_s2   (mat_s2),
		.side_s2  (side_s2),
		.arm      (arm_q),
		.valid_s4 (valid_s4),
		.rot_s4   (rot_s4),
		.side_s4  (side_s4)
	);

	always_comb begin
		dif_x = DIFW'(side_s4.pos.x) - DIFW'(rot_s4.x);
		dif_y = DIFW'(side_s4.pos.y) - DIFW'(rot_s4.y);
		dif_z = DIFW'(side_s4.pos.z) - DIFW'(rot_s4.z);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		center_s5.x <= qlao_pkg::sat_pw(dif_x);
		center_s5.y <= qlao_pkg::sat_pw(dif_y);
		center_s5.z <= qlao_pkg::sat_pw(dif_z);
		conf_s5     <= side_s4.conf;
	end

	assign done           = valid_s5;
	assign center_x       = center_s5.x;
	assign center_y       = center_s5.y;
	assign center_z       = center_s5.z;
	assign confidence_out = conf_s5;

	done_latency_a: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 5))
		else $error("result beat without a pose five cycles earlier");

	conf_carry_a: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (confidence_out == $past(confidence, 5)))
		else $error("confidence not carried with its pose");

	zero_arm_a: assert property (@(posedge clk) disable iff (!arst_n)
		(done && arm_q.x == '0 && arm_q.y == '0 && arm_q.z == '0) |->
		(center_x == $past(pos_x, 5) && center_y == $past(pos_y, 5) &&
		 center_z == $past(pos_z, 5)))
		else $error("zero lever arm changed the position");

endmodule

`default_nettype wire

/* sv/qlao_prod.sv */
// stage one: the ten pairwise products of the quaternion components
// depends on qlao_pkg
`default_nettype none

module qlao_prod (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire qlao_pkg::quat_t  quat,
	input  wire qlao_pkg::side_t  side,
	output logic                  valid_s1,
	output qlao_pkg::prod_t       prod_s1,
	output qlao_pkg::side_t       side_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1.ww <= quat.w * quat.w;
		prod_s1.xx <= quat.x * quat.x;
		prod_s1.yy <= quat.y * quat.y;
		prod_s1.zz <= quat.z * quat.z;
		prod_s1.wx <= quat.w * quat.x;
		prod_s1.wy <= quat.w * quat.y;
		prod_s1.wz <= quat.w * quat.z;
		prod_s1.xy <= quat.x * quat.y;
		prod_s1.xz <= quat.x * quat.z;
		prod_s1.yz <= quat.y * quat.z;
		side_s1    <= side;
	end

endmodule

`default_nettype wire

/* sv/qlao_matrix.sv */
// stage two: norm window test and rotation matrix entries with scale 2
// depends on qlao_pkg
`default_nettype none

module qlao_matrix (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid_s1,
	input  wire qlao_pkg::prod_t  prod_s1,
	input  wire qlao_pkg::side_t  side_s1,
	output logic                  valid_s2,
	output qlao_pkg::mat_t        mat_s2,
	output qlao_pkg::side_t       side_s2
);

	localparam int ENTW = qlao_pkg::ENTW;

	logic signed [ENTW-1:0] norm;
	logic                   norm_ok;
	logic signed [ENTW-1:0] xx2, yy2, zz2, wx2, wy2, wz2, xy2, xz2, yz2;
	qlao_pkg::mat_t         mat;

	always_comb begin
		norm = ENTW'(prod_s1.ww) + ENTW'(prod_s1.xx) + ENTW'(prod_s1.yy) + ENTW'(prod_s1.zz);
		norm_ok = (norm >= qlao_pkg::NORM_LO) && (norm <= qlao_pkg::NORM_HI);

		xx2 = ENTW'(prod_s1.xx) <<< 1;
		yy2 = ENTW'(prod_s1.yy) <<< 1;
		zz2 = ENTW'(prod_s1.zz) <<< 1;
		wx2 = ENTW'(prod_s1.wx) <<< 1;
		wy2 = ENTW'(prod_s1.wy) <<< 1;
		wz2 = ENTW'(prod_s1.wz) <<< 1;
		xy2 = ENTW'(prod_s1.xy) <<< 1;
		xz2 = ENTW'(prod_s1.xz) <<< 1;
		yz2 = ENTW'(prod_s1.yz) <<< 1;

		mat.r00 = qlao_pkg::ONE_Q32 - (yy2 + zz2);
		mat.r01 = xy2 - wz2;
		mat.r02 = xz2 + wy2;
		mat.r10 = xy2 + wz2;
		mat.r11 = qlao_pkg::ONE_Q32 - (xx2 + zz2);
		mat.r12 = yz2 - wx2;
		mat.r20 = xz2 - wy2;
		mat.r21 = yz2 + wx2;
		mat.r22 = qlao_pkg::ONE_Q32 - (xx2 + yy2);
	end

	// poses off the unit sphere are dropped here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1 && norm_ok;
		end
	end

	always_ff @(posedge clk) begin
		mat_s2  <= mat;
		side_s2 <= side_s1;
	end

	dropped_pose_a: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !norm_ok) |=> !valid_s2)
		else $error("pose outside norm window passed on");

endmodule

`default_nettype wire

/* sv/qlao_rotate.sv */
// stages three and four: matrix times lever arm, then row sums rounded to Q16.16
// depends on qlao_pkg
`default_nettype none

module qlao_rotate (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid_s2,
	input  wire qlao_pkg::mat_t   mat_s2,
	input  wire qlao_pkg::side_t  side_s2,
	input  wire qlao_pkg::arm_t   arm,
	output logic                  valid_s4,
	output qlao_pkg::rot_t        rot_s4,
	output qlao_pkg::side_t       side_s4
);

	localparam int MULW  = qlao_pkg::MULW;
	localparam int SUMW  = qlao_pkg::SUMW;
	localparam int FRACW = qlao_pkg::FRACW;

	logic                   valid_s3;
	qlao_pkg::side_t        side_s3;
	logic signed [MULW-1:0] p00_s3, p01_s3, p02_s3;
	logic signed [MULW-1:0] p10_s3, p11_s3, p12_s3;
	logic signed [MULW-1:0] p20_s3, p21_s3, p22_s3;
	logic signed [SUMW-1:0] sum_x, sum_y, sum_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		p00_s3  <= mat_s2.r00 * arm.x;
		p01_s3  <= mat_s2.r01 * arm.y;
		p02_s3  <= mat_s2.r02 * arm.z;
		p10_s3  <= mat_s2.r10 * arm.x;
		p11_s3  <= mat_s2.r11 * arm.y;
		p12_s3  <= mat_s2.r12 * arm.z;
		p20_s3  <= mat_s2.r20 * arm.x;
		p21_s3  <= mat_s2.r21 * arm.y;
		p22_s3  <= mat_s2.r22 * arm.z;
		side_s3 <= side_s2;
	end

	// add half an lsb, then floor: round to nearest, ties up
	always_comb begin
		sum_x = SUMW'(p00_s3) + SUMW'(p01_s3) + SUMW'(p02_s3) + qlao_pkg::HALF_Q32;
		sum_y = SUMW'(p10_s3) + SUMW'(p11_s3) + SUMW'(p12_s3) + qlao_pkg::HALF_Q32;
		sum_z = SUMW'(p20_s3) + SUMW'(p21_s3) + SUMW'(p22_s3) + qlao_pkg::HALF_Q32;
	end

	always_ff @(posedge clk) begin
		rot_s4.x <= sum_x[SUMW-1:FRACW];
		rot_s4.y <= sum_y[SUMW-1:FRACW];
		rot_s4.z <= sum_z[SUMW-1:FRACW];
		side_s4  <= side_s3;
	end

	valid_follows_a: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> $past(valid_s2, 2))
		else $error("rotation stage valid without an entering beat");

endmodule

`default_nettype wire
